@@ rtl/frlp_pkg.sv @@
package frlp_pkg;

   localparam int unsigned FLASH_BYTES  = 8388608;
   localparam int unsigned SECTOR_BYTES = 4096;
   localparam int unsigned MAX_RECORD   = 1536;

   localparam int LEN_W    = 12;
   localparam int ADDR_W   = 23;
   localparam int END_W    = 24;
   localparam int SUM_W    = END_W + 1;
   localparam int SECTOR_W = $clog2(SECTOR_BYTES);

   localparam logic ACTION_APPEND  = 1'b0;
   localparam logic ACTION_RELEASE = 1'b1;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef struct packed {
      logic              action;
      logic [LEN_W-1:0]  record_len;
      logic [ADDR_W-1:0] release_addr;
   } req_type;

   typedef struct packed {
      logic              status;
      logic [ADDR_W-1:0] write_addr;
      logic [END_W-1:0]  write_end;
      logic [ADDR_W-1:0] read_start;
      logic              exhausted;
      logic              wrapped;
   } rsp_type;

   typedef struct packed {
      logic [END_W-1:0]  write_ptr;
      logic [ADDR_W-1:0] read_ptr;
      logic              overrun;
   } ptr_state_type;

endpackage

@@ rtl/frlp_update.sv @@
module frlp_update (
   input  frlp_pkg::req_type       req,
   input  frlp_pkg::ptr_state_type cur,
   output frlp_pkg::ptr_state_type nxt,
   output frlp_pkg::rsp_type       rsp
);
   import frlp_pkg::*;

   logic [SUM_W-1:0]  w_ext;
   logic [SUM_W-1:0]  r_ext;
   logic [SUM_W-1:0]  sum;
   logic              reach_end;
   logic              reject;
   logic [SUM_W-1:0]  addr;
   logic [SUM_W-1:0]  new_w;
   logic [SUM_W-1:0]  boundary;
   logic [ADDR_W-1:0] past;
   logic              move_r;
   logic              set_flag;

   assign w_ext     = SUM_W'(cur.write_ptr);
   assign r_ext     = SUM_W'(cur.read_ptr);
   assign sum       = w_ext + SUM_W'(req.record_len);
   assign reach_end = sum >= SUM_W'(FLASH_BYTES);
   assign reject    = (req.record_len == '0) || (req.record_len > LEN_W'(MAX_RECORD));
   assign addr      = reach_end ? '0 : w_ext;
   assign new_w     = addr + SUM_W'(req.record_len);

   // next sector boundary strictly past the new write end, zero at or past the flash end
   assign boundary = {new_w[SUM_W-1:SECTOR_W], {SECTOR_W{1'b0}}} + SUM_W'(SECTOR_BYTES);
   assign past     = (boundary >= SUM_W'(FLASH_BYTES)) ? '0 : boundary[ADDR_W-1:0];

   always_comb begin
      move_r   = 1'b0;
      set_flag = 1'b0;
      if (w_ext > r_ext) begin
         if (reach_end && (new_w > r_ext)) begin
            move_r   = 1'b1;
            set_flag = 1'b1;
         end
      end else if (w_ext < r_ext) begin
         if (reach_end || cur.overrun || (sum >= r_ext)) begin
            move_r   = 1'b1;
            set_flag = 1'b1;
         end
      end else begin
         move_r = cur.overrun;
      end
   end

   always_comb begin
      nxt            = cur;
      rsp.status     = STATUS_OK;
      rsp.write_addr = '0;
      rsp.wrapped    = 1'b0;
      if (req.action == ACTION_RELEASE) begin
         nxt.read_ptr = req.release_addr;
         nxt.overrun  = 1'b0;
      end else if (reject) begin
         rsp.status = STATUS_REJECT;
      end else begin
         rsp.write_addr = addr[ADDR_W-1:0];
         rsp.wrapped    = reach_end;
         nxt.write_ptr  = new_w[END_W-1:0];
         if (move_r) begin
            nxt.read_ptr = past;
         end
         if (set_flag) begin
            nxt.overrun = 1'b1;
         end
      end
      rsp.write_end  = nxt.write_ptr;
      rsp.read_start = nxt.read_ptr;
      rsp.exhausted  = nxt.overrun;
   end

endmodule

@@ rtl/flash_ring_log_pointer_manager.sv @@
// Pointer manager for a circular record log in serial flash. Each request word is an
// append (record length) or a release (new read start after an upload); each produces
// exactly one response word with the write address, the updated write end and read
// start pointers, the exhausted flag and a wrap indication. A request is taken into an
// input register, the pointer update runs combinationally from there into the response
// register, so the block sustains one word per cycle; it stalls only when the response
// register is full and the consumer stalls.
module flash_ring_log_pointer_manager (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  frlp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output frlp_pkg::rsp_type rsp_data
);
   import frlp_pkg::*;

   logic          in_valid_ff;
   req_type       in_data_ff;
   logic          out_valid_ff;
   logic          out_valid_in;
   rsp_type       out_data_ff;
   ptr_state_type st_ff;
   ptr_state_type st_in;
   rsp_type       rsp_calc;
   logic          advance;
   logic          take;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   frlp_update u_update (
      .req (in_data_ff),
      .cur (st_ff),
      .nxt (st_in),
      .rsp (rsp_calc)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         st_ff        <= '0;
      end else begin
         if (take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         out_valid_ff <= out_valid_in;
         if (advance) begin
            st_ff <= st_in;
         end
      end
   end

   // hold the input word until it moves on
   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= rsp_calc;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("request stalled without a full pipeline");

   a_state_matches_rsp: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_data_ff.write_end == st_ff.write_ptr &&
                        out_data_ff.read_start == st_ff.read_ptr &&
                        out_data_ff.exhausted == st_ff.overrun))
      else $error("pointer state diverged from last response");

   a_wrap_at_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.wrapped) |-> (out_data_ff.write_addr == '0))
      else $error("wrapped write not at address zero");

   a_reject_no_change: assert property (@(posedge clock) disable iff (reset)
      (advance && rsp_calc.status == STATUS_REJECT) |=> (st_ff == $past(st_ff)))
      else $error("rejected append changed the pointers");

endmodule
